>>> sv/urxfld_pkg.sv
// shared types, constants and keyword tables for the uart receive fifo with line detect
// no dependencies
`timescale 1ns / 1ps

package urxfld_pkg;

  localparam int FIFO_DEPTH    = 512;
  localparam int LINE_CAPACITY = 64;

  localparam int FIFO_AW  = $clog2(FIFO_DEPTH);
  localparam int FILL_W   = 9;
  localparam int LINE_LW  = $clog2(LINE_CAPACITY);
  localparam int KEEP_MAX = LINE_CAPACITY - 1;

  localparam int KW_ON_LEN  = 9;
  localparam int KW_OFF_LEN = 12;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;

  typedef logic [FIFO_AW-1:0] ptr_t;
  typedef logic [7:0]         byte_t;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_READ = 2'd1,
    OP_SCAN = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_SCAN_ISSUE,
    ST_SCAN_BYTE,
    ST_DONE
  } state_t;

  // status from the line assembler back to the sequencer
  typedef struct packed {
    logic connected;
    logic hit;
  } line_stat_t;

  // "CONNECTED"
  function automatic byte_t kw_on_char(input logic [3:0] idx);
    byte_t c;
    case (idx)
      4'd0:    c = "C";
      4'd1:    c = "O";
      4'd2:    c = "N";
      4'd3:    c = "N";
      4'd4:    c = "E";
      4'd5:    c = "C";
      4'd6:    c = "T";
      4'd7:    c = "E";
      4'd8:    c = "D";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "DISCONNECTED"
  function automatic byte_t kw_off_char(input logic [3:0] idx);
    byte_t c;
    case (idx)
      4'd0:    c = "D";
      4'd1:    c = "I";
      4'd2:    c = "S";
      4'd3:    c = "C";
      4'd4:    c = "O";
      4'd5:    c = "N";
      4'd6:    c = "N";
      4'd7:    c = "E";
      4'd8:    c = "C";
      4'd9:    c = "T";
      4'd10:   c = "E";
      4'd11:   c = "D";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

>>> sv/uart_rx_fifo_status_line_detect_core.sv
// top level: request sequencer, fifo pointers and result register
// depends on urxfld_pkg, urxfld_fifo_ram, urxfld_line_det
`timescale 1ns / 1ps

// uart receive ring fifo with status line detection. one request is taken at a
// time and gives exactly one result. a push writes the ram at accept and its
// result is loaded in the done state; a host read passes through a read state
// because the fifo ram has a registered read port; a scan alternates an issue
// state and a byte state, one ram read and one line assembler step per byte. the fifo
// holds at most 511 bytes, a push into a full fifo is dropped and flagged. the
// input side is stalled while a request is in progress; the result sits in an
// output register, so a new request is accepted while the last result waits.
// a result that cannot leave because the output stays stalled holds the
// sequencer in its final state until the register frees up.

module uart_rx_fifo_status_line_detect_core import urxfld_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_opcode,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [7:0]        out_read_byte,
  output logic              out_read_valid,
  output logic              out_byte_dropped,
  output logic              out_link_connected,
  output logic              out_status_changed,
  output logic [FILL_W-1:0] out_fill_level
);

  state_t state_r, state_nxt;

  // fifo pointers
  ptr_t wp_r, wp_nxt;
  ptr_t rp_r, rp_nxt;

  // per-request result under construction
  op_t   op_r, op_nxt;
  byte_t res_byte_r, res_byte_nxt;
  logic  res_rv_r, res_rv_nxt;
  logic  res_drop_r, res_drop_nxt;
  logic  res_chg_r, res_chg_nxt;

  // output register
  logic              out_valid_r, out_valid_nxt;
  byte_t             out_byte_r;
  logic              out_rv_r;
  logic              out_drop_r;
  logic              out_conn_r;
  logic              out_chg_r;
  logic [FILL_W-1:0] out_fill_r;

  logic       in_acc;
  logic       out_free;
  logic       load_out;
  logic       mem_we;
  logic       mem_re;
  byte_t      mem_rdata;
  logic       line_bv;
  line_stat_t line_stat;
  logic       fifo_empty;
  logic       fifo_full;
  ptr_t       wp_adv;
  ptr_t       rp_adv;
  logic [FIFO_AW:0] fill;

  function automatic ptr_t advance(input ptr_t p);
    ptr_t q;
    if (p == ptr_t'(FIFO_DEPTH - 1)) begin
      q = '0;
    end else begin
      q = p + ptr_t'(1);
    end
    return q;
  endfunction

  assign wp_adv     = advance(wp_r);
  assign rp_adv     = advance(rp_r);
  assign fifo_empty = (rp_r == wp_r);
  assign fifo_full  = (wp_adv == rp_r);

  always_comb begin
    if (wp_r >= rp_r) begin
      fill = {1'b0, wp_r} - {1'b0, rp_r};
    end else begin
      fill = {1'b0, wp_r} + (FIFO_AW+1)'(FIFO_DEPTH) - {1'b0, rp_r};
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  urxfld_fifo_ram u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wp_r),
    .wdata (in_rx_byte),
    .re    (mem_re),
    .raddr (rp_r),
    .rdata (mem_rdata)
  );

  urxfld_line_det u_line (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (line_bv),
    .byte_in    (mem_rdata),
    .stat       (line_stat)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (op_t'(in_opcode))
            OP_READ: state_nxt = fifo_empty ? ST_DONE : ST_READ;
            OP_SCAN: state_nxt = ST_SCAN_ISSUE;
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_READ:       state_nxt = ST_DONE;
      ST_SCAN_ISSUE: state_nxt = fifo_empty ? ST_DONE : ST_SCAN_BYTE;
      ST_SCAN_BYTE:  state_nxt = ST_SCAN_ISSUE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:       state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    line_bv      = 1'b0;
    load_out     = 1'b0;
    wp_nxt       = wp_r;
    rp_nxt       = rp_r;
    op_nxt       = op_r;
    res_byte_nxt = res_byte_r;
    res_rv_nxt   = res_rv_r;
    res_drop_nxt = res_drop_r;
    res_chg_nxt  = res_chg_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          op_nxt       = op_t'(in_opcode);
          res_byte_nxt = '0;
          res_rv_nxt   = 1'b0;
          res_drop_nxt = 1'b0;
          res_chg_nxt  = 1'b0;
          case (op_t'(in_opcode))
            OP_PUSH: begin
              if (fifo_full) begin
                res_drop_nxt = 1'b1;
              end else begin
                mem_we = 1'b1;
                wp_nxt = wp_adv;
              end
            end
            OP_READ: begin
              if (!fifo_empty) begin
                mem_re = 1'b1;
                rp_nxt = rp_adv;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        res_byte_nxt = mem_rdata;
        res_rv_nxt   = 1'b1;
      end
      ST_SCAN_ISSUE: begin
        if (!fifo_empty) begin
          mem_re = 1'b1;
          rp_nxt = rp_adv;
        end
      end
      ST_SCAN_BYTE: begin
        line_bv     = 1'b1;
        res_chg_nxt = res_chg_r || line_stat.hit;
      end
      ST_DONE: begin
        load_out = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      rp_r        <= '0;
      out_valid_r <= 1'b0;
      op_r        <= OP_NONE;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      rp_r        <= rp_nxt;
      out_valid_r <= out_valid_nxt;
      op_r        <= op_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    res_byte_r <= res_byte_nxt;
    res_rv_r   <= res_rv_nxt;
    res_drop_r <= res_drop_nxt;
    res_chg_r  <= res_chg_nxt;
    if (load_out) begin
      out_byte_r <= res_byte_r;
      out_rv_r   <= res_rv_r;
      out_drop_r <= res_drop_r;
      out_conn_r <= line_stat.connected;
      out_chg_r  <= res_chg_r;
      out_fill_r <= fill[FILL_W-1:0];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_byte      = out_byte_r;
  assign out_read_valid     = out_rv_r;
  assign out_byte_dropped   = out_drop_r;
  assign out_link_connected = out_conn_r;
  assign out_status_changed = out_chg_r;
  assign out_fill_level     = out_fill_r;

  // a stalled result is never lost
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_byte_r) && $stable(out_fill_r))
    else $error("stalled result changed or vanished");

  // a dropped push leaves the write pointer alone
  a_drop_keeps_wp: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_opcode == OP_PUSH) && fifo_full |=> $stable(wp_r))
    else $error("write pointer moved on a dropped push");

  // a scan only finishes once the fifo is drained
  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) && (op_r == OP_SCAN) |-> fifo_empty)
    else $error("scan finished with bytes left in fifo");

  // a read result and a drop flag never come together
  a_rv_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_rv_r && out_drop_r))
    else $error("read result carries a drop flag");

  // the line assembler only steps during a scan
  a_line_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    line_bv |-> (op_r == OP_SCAN) && $past(mem_re))
    else $error("line assembler stepped outside a scan");

endmodule

>>> sv/urxfld_fifo_ram.sv
// byte storage of the receive ring fifo, one write and one registered read port
// depends on urxfld_pkg
`timescale 1ns / 1ps

module urxfld_fifo_ram import urxfld_pkg::*; (
  input  logic  clk,
  input  logic  we,
  input  ptr_t  waddr,
  input  byte_t wdata,
  input  logic  re,
  input  ptr_t  raddr,
  output byte_t rdata
);

  byte_t mem [FIFO_DEPTH];
  byte_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/urxfld_line_det.sv
// line assembler: tracks line length and running keyword prefix matches, holds link flag
// depends on urxfld_pkg
`timescale 1ns / 1ps

module urxfld_line_det import urxfld_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  byte_t      byte_in,
  output line_stat_t stat
);

  logic [LINE_LW-1:0] len_r, len_nxt;
  logic               on_ok_r, on_ok_nxt;
  logic               off_ok_r, off_ok_nxt;
  logic               conn_r, conn_nxt;
  logic               hit;
  logic               is_eol;

  assign is_eol = (byte_in == CHAR_LF) || (byte_in == CHAR_CR);

  always_comb begin
    len_nxt    = len_r;
    on_ok_nxt  = on_ok_r;
    off_ok_nxt = off_ok_r;
    conn_nxt   = conn_r;
    hit        = 1'b0;
    if (byte_valid) begin
      if (is_eol) begin
        if (len_r != '0) begin
          if (on_ok_r && (len_r == LINE_LW'(KW_ON_LEN))) begin
            conn_nxt = 1'b1;
            hit      = 1'b1;
          end else if (off_ok_r && (len_r == LINE_LW'(KW_OFF_LEN))) begin
            conn_nxt = 1'b0;
            hit      = 1'b1;
          end
          len_nxt    = '0;
          on_ok_nxt  = 1'b1;
          off_ok_nxt = 1'b1;
        end
      end else if (len_r < LINE_LW'(KEEP_MAX)) begin
        // kept character must sit inside the keyword and equal it
        on_ok_nxt  = on_ok_r && (len_r < LINE_LW'(KW_ON_LEN))
                     && (byte_in == kw_on_char(len_r[3:0]));
        off_ok_nxt = off_ok_r && (len_r < LINE_LW'(KW_OFF_LEN))
                     && (byte_in == kw_off_char(len_r[3:0]));
        len_nxt    = len_r + LINE_LW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r    <= '0;
      on_ok_r  <= 1'b1;
      off_ok_r <= 1'b1;
      conn_r   <= 1'b0;
    end else begin
      len_r    <= len_nxt;
      on_ok_r  <= on_ok_nxt;
      off_ok_r <= off_ok_nxt;
      conn_r   <= conn_nxt;
    end
  end

  assign stat.connected = conn_r;
  assign stat.hit       = hit;

endmodule

>>> dv/uart_rx_fifo_status_line_detect_core_tb.sv
// self-checking testbench for uart_rx_fifo_status_line_detect_core
// depends on urxfld_pkg and the core rtl; holds its own fifo and line predictor
`timescale 1ns / 1ps

module uart_rx_fifo_status_line_detect_core_tb;
  import urxfld_pkg::*;

  localparam int HALF_PERIOD  = 4;
  localparam int RESET_CYCLES = 10;
  localparam int RANDOM_ITEMS = 1350;
  localparam int FLOOD_PUSHES = 520;
  // well above the length of a full scan of 511 buffered bytes
  localparam int QUIET_LIMIT  = 8000;
  localparam int END_CYCLES   = 32;

  localparam string ON_WORD  = "CONNECTED";
  localparam string OFF_WORD = "DISCONNECTED";

  // one result of the block, field order matches the output ports
  typedef struct packed {
    byte_t             read_byte;
    logic              read_valid;
    logic              byte_dropped;
    logic              link_connected;
    logic              status_changed;
    logic [FILL_W-1:0] fill_level;
  } rx_status_t;

  // predictor: ring fifo, line assembler and connected flag, one status per request
  class rx_line_scoreboard;
    byte_t        fifo_mem [FIFO_DEPTH];
    ptr_t         wr_ptr = '0;
    ptr_t         rd_ptr = '0;
    byte_t        kept_chars [KEEP_MAX];
    int unsigned  line_len = 0;
    logic         connected = 1'b0;
    rx_status_t   expected_status [$];
    int unsigned  mismatches = 0;

    function bit line_equals(string word);
      if (line_len != word.len()) return 1'b0;
      for (int i = 0; i < word.len(); i++)
        if (kept_chars[i] != word[i]) return 1'b0;
      return 1'b1;
    endfunction

    function void note_request(op_t op, byte_t data);
      rx_status_t st;
      byte_t      c;
      st = '0;
      case (op)
        OP_PUSH: begin
          // one slot stays free, so a full fifo holds 511 bytes
          if (ptr_t'(wr_ptr + 1'b1) != rd_ptr) begin
            fifo_mem[wr_ptr] = data;
            wr_ptr = ptr_t'(wr_ptr + 1'b1);
          end else begin
            st.byte_dropped = 1'b1;
          end
        end
        OP_READ: begin
          if (rd_ptr != wr_ptr) begin
            st.read_byte  = fifo_mem[rd_ptr];
            st.read_valid = 1'b1;
            rd_ptr = ptr_t'(rd_ptr + 1'b1);
          end
        end
        OP_SCAN: begin
          while (rd_ptr != wr_ptr) begin
            c = fifo_mem[rd_ptr];
            rd_ptr = ptr_t'(rd_ptr + 1'b1);
            if (c == CHAR_LF || c == CHAR_CR) begin
              // empty lines are skipped
              if (line_len != 0) begin
                if (line_equals(ON_WORD)) begin
                  connected = 1'b1;
                  st.status_changed = 1'b1;
                end else if (line_equals(OFF_WORD)) begin
                  connected = 1'b0;
                  st.status_changed = 1'b1;
                end
                line_len = 0;
              end
            end else if (line_len < KEEP_MAX) begin
              kept_chars[line_len] = c;
              line_len++;
            end
          end
        end
        default: ;
      endcase
      st.link_connected = connected;
      st.fill_level     = FILL_W'(wr_ptr - rd_ptr);
      expected_status.push_back(st);
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        mismatches++;
        $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_status(rx_status_t got);
      rx_status_t want;
      if (expected_status.size() == 0) begin
        mismatches++;
        $display("%0t mismatch: expected no result, actual %h", $time, got);
        return;
      end
      want = expected_status.pop_front();
      compare_field("read_byte", want.read_byte, got.read_byte);
      compare_field("read_valid", want.read_valid, got.read_valid);
      compare_field("byte_dropped", want.byte_dropped, got.byte_dropped);
      compare_field("link_connected", want.link_connected, got.link_connected);
      compare_field("status_changed", want.status_changed, got.status_changed);
      compare_field("fill_level", want.fill_level, got.fill_level);
    endfunction

    function int unsigned pending_count();
      return expected_status.size();
    endfunction
  endclass

  // clock, reset and block inputs, all known from time zero
  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_valid   = 1'b0;
  logic [1:0]        in_opcode  = OP_PUSH;
  logic [7:0]        in_rx_byte = 8'h00;
  logic              out_stall  = 1'b0;
  logic              in_stall;
  logic              out_valid;
  logic [7:0]        out_read_byte;
  logic              out_read_valid;
  logic              out_byte_dropped;
  logic              out_link_connected;
  logic              out_status_changed;
  logic [FILL_W-1:0] out_fill_level;

  rx_line_scoreboard sb;
  rx_status_t        seen_status;
  byte_t             line_q [$];
  int unsigned       send_idle_pct = 0;
  int unsigned       stall_pct     = 0;
  int unsigned       sent_count    = 0;
  int unsigned       quiet_cycles  = 0;

  always #(HALF_PERIOD) clk = ~clk;

  uart_rx_fifo_status_line_detect_core uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_rx_byte         (in_rx_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_byte      (out_read_byte),
    .out_read_valid     (out_read_valid),
    .out_byte_dropped   (out_byte_dropped),
    .out_link_connected (out_link_connected),
    .out_status_changed (out_status_changed),
    .out_fill_level     (out_fill_level)
  );

  assign seen_status = {out_read_byte, out_read_valid, out_byte_dropped,
                        out_link_connected, out_status_changed, out_fill_level};

  // receiver side: random stall, the rate set per phase
  always @(posedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  // result monitor: values read here are the ones present at the edge
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_status(seen_status);
  end

  // watchdog: counts cycles in which neither channel moves anything
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t watchdog: no handshake for %0d cycles", $time, QUIET_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one request: optional idle gap, then hold valid and payload until accepted.
  // valid is left high afterwards, the next call lowers it only for a gap
  task automatic send_req(input op_t op, input byte_t data);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_rx_byte <= data;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, data);
    if (op != OP_NONE) sent_count++;
  endtask

  // sender holds off until every outstanding result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending_count() != 0);
  endtask

  task automatic push_line_q();
    while (line_q.size() != 0) send_req(OP_PUSH, line_q.pop_front());
  endtask

  task automatic add_word(input string word);
    for (int i = 0; i < word.len(); i++) line_q.push_back(word[i]);
  endtask

  function automatic byte_t pick_term();
    return $urandom_range(1) ? CHAR_CR : CHAR_LF;
  endfunction

  // any byte but a line terminator
  function automatic byte_t text_byte();
    byte_t b;
    do b = byte_t'($urandom); while (b == CHAR_CR || b == CHAR_LF);
    return b;
  endfunction

  function automatic string pick_word();
    return $urandom_range(1) ? ON_WORD : OFF_WORD;
  endfunction

  // short hand-picked opening: empty fifo, unused opcode, byte extremes,
  // empty lines, a keyword, a line split across two scans and a repeated match
  task automatic directed_part();
    send_req(OP_READ, 8'hFF);     // read of an empty fifo
    send_req(OP_NONE, 8'hA5);     // unused opcode changes nothing
    send_req(OP_SCAN, 8'h00);     // scan with nothing buffered
    send_req(OP_PUSH, 8'h00);
    send_req(OP_PUSH, 8'hFF);
    send_req(OP_READ, 8'h00);
    send_req(OP_READ, 8'h00);
    line_q.push_back(CHAR_CR);
    line_q.push_back(CHAR_LF);
    add_word(ON_WORD);
    line_q.push_back(CHAR_CR);
    push_line_q();
    send_req(OP_SCAN, 8'h00);
    // unterminated part stays in the assembler until the next scan
    add_word("CONNE");
    push_line_q();
    send_req(OP_SCAN, 8'h00);
    add_word("CTED");
    line_q.push_back(CHAR_LF);
    push_line_q();
    send_req(OP_SCAN, 8'h00);
  endtask

  // fill the fifo to the brim and past it, then drain it with one scan
  task automatic flood_fifo();
    repeat (FLOOD_PUSHES) send_req(OP_PUSH, byte_t'($urandom));
    send_req(OP_READ, byte_t'($urandom));
    send_req(OP_SCAN, byte_t'($urandom));
  endtask

  // one random sequence; mostly keyword lines with random framing
  task automatic random_sequence();
    int unsigned pick;
    int unsigned n;
    int unsigned idx;
    pick = $urandom_range(99);
    line_q.delete();
    if (pick < 30) begin
      // well-formed status line, maybe behind empty lines
      n = $urandom_range(2);
      repeat (n) line_q.push_back(pick_term());
      add_word(pick_word());
      line_q.push_back(pick_term());
      push_line_q();
      if ($urandom_range(99) < 60) send_req(OP_SCAN, byte_t'($urandom));
    end else if (pick < 42) begin
      // near miss: one byte changed, one short, or an extra zero byte
      add_word(pick_word());
      case ($urandom_range(3))
        0: begin
          idx = $urandom_range(line_q.size() - 1);
          line_q[idx] = text_byte();
        end
        1: void'(line_q.pop_back());
        2: line_q.push_back(8'h00);
        default: line_q.push_front(8'h00);
      endcase
      line_q.push_back(pick_term());
      push_line_q();
      send_req(OP_SCAN, byte_t'($urandom));
    end else if (pick < 52) begin
      repeat ($urandom_range(1, 4)) send_req(OP_READ, byte_t'($urandom));
    end else if (pick < 60) begin
      send_req(OP_SCAN, byte_t'($urandom));
    end else if (pick < 68) begin
      // raw noise, terminators included
      repeat ($urandom_range(1, 8)) send_req(OP_PUSH, byte_t'($urandom));
    end else if (pick < 73) begin
      // line around and past the kept length, sometimes led by a keyword
      if ($urandom_range(1)) add_word(pick_word());
      n = $urandom_range(52, 80);
      repeat (n) line_q.push_back(text_byte());
      line_q.push_back(pick_term());
      push_line_q();
      send_req(OP_SCAN, byte_t'($urandom));
    end else if (pick < 77) begin
      send_req(OP_NONE, byte_t'($urandom));
    end else if (pick < 87) begin
      // keyword split across two scans
      add_word(pick_word());
      n = $urandom_range(1, line_q.size() - 1);
      repeat (n) send_req(OP_PUSH, line_q.pop_front());
      send_req(OP_SCAN, byte_t'($urandom));
      line_q.push_back(pick_term());
      push_line_q();
      send_req(OP_SCAN, byte_t'($urandom));
    end else begin
      // status line with host reads stealing bytes before the scan
      add_word(pick_word());
      line_q.push_back(pick_term());
      push_line_q();
      repeat ($urandom_range(1, 3)) send_req(OP_READ, byte_t'($urandom));
      send_req(OP_SCAN, byte_t'($urandom));
    end
  endtask

  initial begin
    int unsigned random_start;
    sb = new;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_part();
    drain_results();

    // four idling phases: none, sender gaps, receiver stalls, both
    random_start = sent_count;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 58; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 58; end
        default: begin send_idle_pct = 34; stall_pct = 34; end
      endcase
      if (ph == 2) flood_fifo();
      while (sent_count - random_start < (ph + 1) * RANDOM_ITEMS / 4)
        random_sequence();
      drain_results();
    end

    // stray results would show up in this window
    repeat (END_CYCLES) @(posedge clk);
    if (sb.pending_count() != 0)
      $display("%0t %0d expected results never arrived", $time, sb.pending_count());
    if (sb.mismatches == 0 && sb.pending_count() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
